>>> src/rlee_pkg.sv
// rlee_pkg: shared types, constants and helper functions of the escaped run-length encoder
// used by rlee_outbuf and rle_escape_encoder_top; no dependencies
`default_nettype none

package rlee_pkg;

	localparam int WORD_BITS_DEF = 64;
	localparam int OUT_W         = 64;
	localparam int MAX_WORDS     = 6;
	localparam int CNT_W         = $clog2(MAX_WORDS + 1);
	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 32;

	// register index within the config space
	localparam logic REG_SYMBOL_WIDTH = 1'b0;

	// symbol width codes
	localparam logic [1:0] WIDTH_8  = 2'd0;
	localparam logic [1:0] WIDTH_16 = 2'd1;
	localparam logic [1:0] WIDTH_32 = 2'd2;
	localparam logic [1:0] WIDTH_64 = 2'd3;

	localparam logic [OUT_W-1:0] ESC_8  = 64'h0;
	localparam logic [OUT_W-1:0] ESC_16 = 64'h7309;
	localparam logic [OUT_W-1:0] ESC_32 = 64'hfa217309;
	localparam logic [OUT_W-1:0] ESC_64 = 64'hd78e00fc9b3e7309;

	localparam logic [OUT_W-1:0] MIN_RUN = 64'd3;

	// words left by one run flush: up to one triple
	typedef struct packed {
		logic [1:0]                count;
		logic [2:0][OUT_W-1:0]     words;
	} flush_t;

	// words caused by one input item, first word at index 0
	typedef struct packed {
		logic [CNT_W-1:0]              count;
		logic [MAX_WORDS-1:0][OUT_W-1:0] words;
	} bundle_t;

	function automatic logic [OUT_W-1:0] esc_word(input logic [1:0] code);
		logic [OUT_W-1:0] w;
		unique case (code)
			WIDTH_8:  w = ESC_8;
			WIDTH_16: w = ESC_16;
			WIDTH_32: w = ESC_32;
			WIDTH_64: w = ESC_64;
			default:  w = ESC_8;
		endcase
		return w;
	endfunction

	function automatic logic [OUT_W-1:0] width_mask(input logic [1:0] code);
		logic [OUT_W-1:0] m;
		unique case (code)
			WIDTH_8:  m = 64'h0000_0000_0000_00ff;
			WIDTH_16: m = 64'h0000_0000_0000_ffff;
			WIDTH_32: m = 64'h0000_0000_ffff_ffff;
			WIDTH_64: m = 64'hffff_ffff_ffff_ffff;
			default:  m = 64'h0000_0000_0000_00ff;
		endcase
		return m;
	endfunction

	// closing a run: short plain runs go out as literals, the rest as a triple
	function automatic flush_t run_flush(
		input logic [OUT_W-1:0] sym,
		input logic [OUT_W-1:0] len,
		input logic [OUT_W-1:0] esc,
		input logic             open_run,
		input logic             escaped
	);
		flush_t f;
		f.count = '0;
		f.words = '0;
		if (open_run && len != '0) begin
			if (!escaped && sym != esc && len < MIN_RUN) begin
				f.count = len[1:0];
				f.words = {3{sym}};
			end else begin
				f.count    = 2'd3;
				f.words[0] = esc;
				f.words[1] = sym;
				f.words[2] = len;
			end
		end
		return f;
	endfunction

endpackage

`default_nettype wire

>>> src/rlee_outbuf.sv
// rlee_outbuf: result buffer holding the words of one input item, drained one per transfer
// depends on rlee_pkg (bundle_t, MAX_WORDS)
`default_nettype none

module rlee_outbuf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  rlee_pkg::bundle_t       load_bundle,
	output logic                    can_load,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [rlee_pkg::OUT_W-1:0] out_word,
	output logic                    out_last
);
	import rlee_pkg::*;

	logic [MAX_WORDS-1:0][OUT_W-1:0] words_q;
	logic [CNT_W-1:0]                count_q;
	logic                            pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_word  = words_q[0];
	assign out_last  = count_q == CNT_W'(1);
	// free now, or freed by the transfer of the last word in this cycle
	assign can_load  = !out_valid || (out_last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (load) begin
			count_q <= load_bundle.count;
		end else if (pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= load_bundle.words;
		end else if (pop) begin
			words_q <= {OUT_W'(0), words_q[MAX_WORDS-1:1]};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(MAX_WORDS))
		else $error("outbuf holds more words than one item can cause");
	assert property (@(posedge clk) disable iff (!arst_n) load |-> can_load)
		else $error("outbuf loaded over words still waiting");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !load) |=> $stable(count_q))
		else $error("outbuf lost a word while stalled");

endmodule

`default_nettype wire

>>> src/rle_escape_encoder_top.sv
// rle_escape_encoder_top: escaped run-length encoder, symbols of 8/16/32/64 bits
// depends on rlee_pkg and rlee_outbuf
//
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+---------------------------
// in      | input     | in_valid / in_ready   | in_symbol[63:0], in_last
// out     | output    | out_valid / out_ready | out_word[63:0], out_last
// cfg     | input     | apb psel/penable      | paddr[2:0], pwdata, prdata
//
// one symbol per cycle: input register, then run compare/update into the result buffer
// an item that causes words (at most six) waits in the input register until the buffer
// has drained; each word leaves in its own transfer, so words bound the rate
// items that cause no word pass at one per cycle even while the output is stalled
// the first word passes the input register, then the result buffer, before it appears
// reset clears the width select and the open run; no clearing pass
`default_nettype none

module rle_escape_encoder_top #(
	parameter int WORD_BITS = rlee_pkg::WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rlee_pkg::OUT_W-1:0]        in_symbol,
	input  logic                              in_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rlee_pkg::OUT_W-1:0]        out_word,
	output logic                              out_last,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rlee_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [rlee_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [rlee_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import rlee_pkg::*;

	// widest width code whose symbols fit in WORD_BITS
	localparam logic [1:0] CODE_MAX = (WORD_BITS >= 64) ? WIDTH_64 :
	                                  (WORD_BITS >= 32) ? WIDTH_32 :
	                                  (WORD_BITS >= 16) ? WIDTH_16 : WIDTH_8;

	logic [1:0]           width_code_q;
	logic                 cfg_write;

	logic                 valid_s1;
	logic [WORD_BITS-1:0] symbol_s1;
	logic                 last_s1;

	logic [WORD_BITS-1:0] run_symbol_q;
	logic [WORD_BITS-1:0] run_length_q;
	logic                 run_open_q;
	logic                 run_escaped_q;

	logic [1:0]           code_eff;
	logic [OUT_W-1:0]     mask64;
	logic [OUT_W-1:0]     esc64;
	logic [WORD_BITS-1:0] mask_k;
	logic [WORD_BITS-1:0] sym_k;
	logic [WORD_BITS-1:0] len_inc;
	logic                 match;
	logic                 capped;

	logic [WORD_BITS-1:0] post_symbol;
	logic [WORD_BITS-1:0] post_length;
	logic                 post_escaped;

	flush_t               flush_a;
	flush_t               flush_b;
	bundle_t              bundle;
	logic [CNT_W-1:0]     tail_idx;

	logic                 can_load;
	logic                 advance;

	// config port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SYMBOL_WIDTH);
	assign prdata    = (paddr[2] == REG_SYMBOL_WIDTH) ? CFG_DATA_W'(width_code_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_code_q <= WIDTH_8;
		end else if (cfg_write) begin
			width_code_q <= pwdata[1:0];
		end
	end

	// input register
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			symbol_s1 <= in_symbol[WORD_BITS-1:0];
			last_s1   <= in_last;
		end
	end

	// run compare and update
	assign code_eff = (width_code_q > CODE_MAX) ? CODE_MAX : width_code_q;
	assign mask64   = width_mask(code_eff);
	assign esc64    = esc_word(code_eff);
	assign mask_k   = mask64[WORD_BITS-1:0];
	assign sym_k    = symbol_s1 & mask_k;
	assign len_inc  = run_length_q + WORD_BITS'(1);
	assign match    = run_open_q && (sym_k == run_symbol_q);
	assign capped   = match && (len_inc == mask_k);

	always_comb begin
		if (match) begin
			post_symbol  = run_symbol_q;
			post_length  = capped ? '0 : len_inc;
			post_escaped = run_escaped_q || capped;
			flush_a.count = capped ? 2'd3 : 2'd0;
			flush_a.words[0] = esc64;
			flush_a.words[1] = OUT_W'(sym_k);
			flush_a.words[2] = mask64;
		end else begin
			post_symbol  = sym_k;
			post_length  = WORD_BITS'(1);
			post_escaped = 1'b0;
			flush_a = run_flush(OUT_W'(run_symbol_q), OUT_W'(run_length_q), esc64,
			                    run_open_q, run_escaped_q);
		end
		flush_b = run_flush(OUT_W'(post_symbol), OUT_W'(post_length), esc64,
		                    1'b1, post_escaped);
		if (!last_s1) begin
			flush_b.count = 2'd0;
		end
	end

	// pack the closing run's or capped chunk's words, then the flushed run's words
	always_comb begin
		bundle.count = CNT_W'(flush_a.count) + CNT_W'(flush_b.count);
		tail_idx     = '0;
		for (int i = 0; i < MAX_WORDS; i++) begin
			tail_idx = CNT_W'(i) - CNT_W'(flush_a.count);
			if (CNT_W'(i) < CNT_W'(flush_a.count) && i < 3) begin
				bundle.words[i] = flush_a.words[i];
			end else if (tail_idx < CNT_W'(3)) begin
				bundle.words[i] = flush_b.words[tail_idx[1:0]];
			end else begin
				bundle.words[i] = '0;
			end
		end
	end

	assign advance = valid_s1 && (bundle.count == '0 || can_load);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_symbol_q  <= '0;
			run_length_q  <= '0;
			run_open_q    <= 1'b0;
			run_escaped_q <= 1'b0;
		end else if (cfg_write) begin
			run_symbol_q  <= '0;
			run_length_q  <= '0;
			run_open_q    <= 1'b0;
			run_escaped_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				run_symbol_q  <= '0;
				run_length_q  <= '0;
				run_open_q    <= 1'b0;
				run_escaped_q <= 1'b0;
			end else begin
				run_symbol_q  <= post_symbol;
				run_length_q  <= post_length;
				run_open_q    <= 1'b1;
				run_escaped_q <= post_escaped;
			end
		end
	end

	rlee_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && bundle.count != '0),
		.load_bundle (bundle),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word),
		.out_last    (out_last)
	);

	assert property (@(posedge clk) disable iff (!arst_n) run_length_q != mask_k)
		else $error("run length reached the cap without a capped triple");
	assert property (@(posedge clk) disable iff (!arst_n) run_escaped_q |-> run_open_q)
		else $error("capped flag set with no open run");
	assert property (@(posedge clk) disable iff (!arst_n) !run_open_q |-> run_length_q == '0)
		else $error("length left over from a closed run");
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1 && !cfg_write) |=> !run_open_q)
		else $error("run still open after a flushing item");

endmodule

`default_nettype wire

>>> tb/sv/rlee_checker.sv
`timescale 1ns / 100ps
// rlee_checker: watches the symbol, word and register ports of the run-length encoder,
// predicts every encoded word and compares it with the word that leaves; needs rlee_pkg

module rlee_checker #(
	parameter int WORD_BITS = rlee_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [rlee_pkg::OUT_W-1:0]      in_symbol,
	input  logic                            in_last,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [rlee_pkg::OUT_W-1:0]      out_word,
	input  logic                            out_last,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rlee_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [rlee_pkg::CFG_DATA_W-1:0] pwdata,
	input  logic [rlee_pkg::CFG_DATA_W-1:0] prdata,
	input  logic                            pready,
	output int                              mismatches,
	output int                              pending
);
	import rlee_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] word;
		logic             last;
	} enc_word_t;

	logic [1:0]       width_code;
	logic [OUT_W-1:0] run_sym;
	logic [OUT_W-1:0] run_len;
	logic             run_open;
	logic             run_esc;
	enc_word_t        expected_words[$];
	logic [OUT_W-1:0] item_words[$];

	// widths that do not fit the word are lowered to the widest one that does
	function automatic logic [1:0] fit_code(input logic [1:0] c);
		logic [1:0] f;
		f = c;
		while (f != WIDTH_8 && (8 << f) > WORD_BITS)
			f = f - 2'd1;
		return f;
	endfunction

	function automatic logic [OUT_W-1:0] sym_mask(input logic [1:0] c);
		case (c)
			WIDTH_8:  return 64'h0000_0000_0000_00ff;
			WIDTH_16: return 64'h0000_0000_0000_ffff;
			WIDTH_32: return 64'h0000_0000_ffff_ffff;
			default:  return 64'hffff_ffff_ffff_ffff;
		endcase
	endfunction

	function automatic logic [OUT_W-1:0] escape_for(input logic [1:0] c);
		case (c)
			WIDTH_8:  return ESC_8;
			WIDTH_16: return ESC_16;
			WIDTH_32: return ESC_32;
			default:  return ESC_64;
		endcase
	endfunction

	task automatic append_word(input logic [OUT_W-1:0] w);
		item_words = {item_words, w};
	endtask

	task automatic clear_run();
		run_sym  = '0;
		run_len  = '0;
		run_open = 1'b0;
		run_esc  = 1'b0;
	endtask

	// short plain runs leave as literals, everything else as escape, symbol, count
	task automatic close_run(input logic [OUT_W-1:0] esc, input logic [OUT_W-1:0] m);
		logic [OUT_W-1:0] s;
		s = run_sym & m;
		if (run_open && run_len != '0) begin
			if (!run_esc && s != esc && run_len < MIN_RUN) begin
				for (int k = 0; k < run_len; k++)
					append_word(s);
			end else begin
				append_word(esc);
				append_word(s);
				append_word(run_len & m);
			end
		end
		run_len = '0;
	endtask

	task automatic encode_symbol(input logic [OUT_W-1:0] din, input logic last);
		logic [1:0]       c;
		logic [OUT_W-1:0] m;
		logic [OUT_W-1:0] esc;
		logic [OUT_W-1:0] s;
		enc_word_t        e;
		c   = fit_code(width_code);
		m   = sym_mask(c);
		esc = escape_for(c) & m;
		s   = din & m;
		item_words.delete();
		if (run_open && s == (run_sym & m)) begin
			run_len = run_len + 1;
			// the count saturates: send the capped chunk now, keep the run going
			if (run_len >= m) begin
				append_word(esc);
				append_word(s);
				append_word(m);
				run_len = '0;
				run_esc = 1'b1;
			end
		end else begin
			close_run(esc, m);
			run_sym  = s;
			run_len  = 1;
			run_open = 1'b1;
			run_esc  = 1'b0;
		end
		if (last) begin
			close_run(esc, m);
			clear_run();
		end
		foreach (item_words[i]) begin
			e.word = item_words[i];
			e.last = (i == item_words.size() - 1);
			expected_words = {expected_words, e};
		end
	endtask

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		enc_word_t head;
		if (!arst_n) begin
			width_code = WIDTH_8;
			clear_run();
			expected_words.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("out_word expected none got %h", out_word);
					mismatches++;
				end else begin
					head = expected_words.pop_front();
					if (out_word !== head.word) begin
						$error("out_word expected %h got %h", head.word, out_word);
						mismatches++;
					end
					if (out_last !== head.last) begin
						$error("out_last expected %b got %b", head.last, out_last);
						mismatches++;
					end
				end
			end
			if (psel && penable && pready && (paddr >> 2) == CFG_ADDR_W'(REG_SYMBOL_WIDTH)) begin
				if (pwrite) begin
					// a width change drops whatever run is open
					width_code = pwdata[1:0];
					clear_run();
				end else if (prdata !== CFG_DATA_W'(width_code)) begin
					$error("prdata expected %h got %h", CFG_DATA_W'(width_code), prdata);
					mismatches++;
				end
			end
			if (in_valid && in_ready)
				encode_symbol(in_symbol, in_last);
			pending = expected_words.size();
		end
	end

endmodule

>>> tb/sv/tb_rle_escape_encoder_top.sv
`timescale 1ns / 100ps
// tb_rle_escape_encoder_top: symbol stimulus, register writes and verdict for the encoder
// depends on rlee_pkg, rle_escape_encoder_top and rlee_checker

module tb_rle_escape_encoder_top;
	import rlee_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int LAT_PAUSE   = 8;
	localparam logic [CFG_ADDR_W-1:0] ADDR_WIDTH  = CFG_ADDR_W'(REG_SYMBOL_WIDTH * 4);
	localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = CFG_ADDR_W'((REG_SYMBOL_WIDTH + 1) * 4);

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [OUT_W-1:0]      in_symbol;
	logic                  in_last;
	logic                  out_valid;
	logic                  out_ready;
	logic [OUT_W-1:0]      out_word;
	logic                  out_last;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	int                    mismatches;
	int                    pending;

	bit bursty    = 1'b0;
	bit hold_req  = 1'b0;
	bit hold_done = 1'b0;
	bit valid_low = 1'b1;
	int idle_cycles;

	always #4 clk = ~clk;

	rle_escape_encoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_symbol (in_symbol),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.out_last  (out_last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	rlee_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_symbol  (in_symbol),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.out_last   (out_last),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (bursty && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 7)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ends the run when no transfer of any kind happens for too long
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// random upper bits above the selected width, which the block must ignore
	function automatic logic [OUT_W-1:0] with_noise(input logic [1:0] code,
	                                                input logic [OUT_W-1:0] low);
		logic [OUT_W-1:0] m;
		m = width_mask(code);
		return ({$urandom, $urandom} & ~m) | (low & m);
	endfunction

	function automatic logic [OUT_W-1:0] pick_low(input logic [1:0] code);
		case ($urandom_range(0, 5))
			0:       return esc_word(code);
			1:       return '0;
			2:       return '1;
			3, 4:    return OUT_W'($urandom_range(1, 3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_symbol(input logic [OUT_W-1:0] sym, input logic last);
		in_valid  <= 1'b1;
		in_symbol <= sym;
		in_last   <= last;
		valid_low = 1'b0;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (bursty && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			valid_low = 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// stop offering, wait for every predicted word, then let in-flight symbols settle
	task automatic settle_block();
		if (!valid_low)
			in_valid <= 1'b0;
		valid_low = 1'b1;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LAT_PAUSE) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
	                          input logic [CFG_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_width(input logic [1:0] code);
		logic [CFG_DATA_W-1:0] data;
		settle_block();
		data      = $urandom;
		data[1:0] = code;
		apb_access(1'b1, ADDR_WIDTH, data);
		apb_access(1'b0, ADDR_WIDTH, '0);
		// writes past the register list must leave width and run alone
		if ($urandom_range(0, 2) == 0)
			apb_access(1'b1, ADDR_UNUSED, $urandom);
	endtask

	task automatic random_runs(input logic [1:0] code, input int n);
		int               sent;
		int               len;
		logic [OUT_W-1:0] low;
		logic             last;
		sent = 0;
		while (sent < n) begin
			low = pick_low(code);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 4);
			for (int k = 0; k < len; k++) begin
				last = ($urandom_range(0, 24) == 0) || (k == len - 1 && $urandom_range(0, 9) == 0);
				send_symbol(with_noise(code, low), last);
				sent++;
			end
		end
	endtask

	task automatic run_phase(input logic [1:0] code, input int n);
		set_width(code);
		bursty = ($urandom_range(0, 3) != 0);
		random_runs(code, n);
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_symbol <= '0;
		in_last   <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the width select, then 8-bit cases
		apb_access(1'b0, ADDR_WIDTH, '0);
		bursty = 1'b1;
		send_symbol(64'h00, 1'b1);
		send_symbol(64'hff, 1'b1);
		for (int k = 0; k < 2; k++) send_symbol(64'h41, k == 1);
		for (int k = 0; k < 3; k++) send_symbol(64'h41, k == 2);
		send_symbol(64'h00, 1'b0);
		send_symbol(64'h00, 1'b0);
		send_symbol(64'h42, 1'b1);
		send_symbol(64'hffff_ffff_ffff_ff41, 1'b0);
		send_symbol(64'h0000_0000_0000_0041, 1'b1);
		for (int k = 0; k < 3; k++) send_symbol(64'h10, 1'b0);
		send_symbol(64'h20, 1'b1);
		// closed triple plus escape flush: six words from one transfer
		for (int k = 0; k < 3; k++) send_symbol(64'h33, 1'b0);
		send_symbol(64'h00, 1'b1);
		// run left open across a width change
		send_symbol(64'h55, 1'b0);
		set_width(WIDTH_16);
		send_symbol(64'h7309, 1'b1);
		send_symbol(64'hffff, 1'b1);
		set_width(WIDTH_64);
		send_symbol(64'hd78e_00fc_9b3e_7309, 1'b1);
		for (int k = 0; k < 2; k++) send_symbol(64'hffff_ffff_ffff_ffff, k == 1);

		// capped chunk, then a one-symbol remainder that still leaves as a triple
		set_width(WIDTH_8);
		bursty = 1'b0;
		repeat (255) send_symbol(with_noise(WIDTH_8, 64'h5a), 1'b0);
		send_symbol(64'h5a, 1'b1);

		run_phase(WIDTH_16, 30);
		run_phase(WIDTH_32, 30);
		// long output hold-off while symbols that cause words keep coming
		hold_req = 1'b1;
		for (int k = 0; k < 30; k++)
			send_symbol(with_noise(WIDTH_32, (k % 3 == 0) ? ESC_32 : OUT_W'(k)), 1'b0);
		run_phase(WIDTH_64, 30);
		run_phase(WIDTH_8, 30);
		run_phase(WIDTH_64, 20);
		run_phase(WIDTH_16, 20);

		// tail without idling on either side
		set_width(WIDTH_32);
		bursty = 1'b0;
		random_runs(WIDTH_32, 20);
		send_symbol(with_noise(WIDTH_32, ESC_32), 1'b1);

		settle_block();
		repeat (LAT_PAUSE * 3) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
src/rlee_pkg.sv
src/rlee_outbuf.sv
src/rle_escape_encoder_top.sv
tb/sv/rlee_checker.sv
tb/sv/tb_rle_escape_encoder_top.sv
